// ----- rtl/core/scba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_pkg: shared types and constants of the size-class block allocator
// Status codes and the controller command bundle.
// ----------------------------------------------------------------------------
package scba_pkg;
	localparam int ADDR_W  = 18;
	localparam int SIZE_W  = 12;
	localparam int USED_W  = 16;
	localparam int COUNT_W = 9;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_SIZE  = 3'd1,
		ST_NO_PAGE   = 3'd2,
		ST_FOREIGN   = 3'd3,
		ST_UNDERFLOW = 3'd4
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture request word
		logic read;     // issue page table reads
		logic link;     // issue link read at the block head
		logic commit;   // apply writes and produce result
	} cmd_t;
endpackage

// ----- rtl/core/scba_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_ctrl: request sequencer
// Steps each word through load, table read, link read and commit, then holds
// the result.
// ----------------------------------------------------------------------------
module scba_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output scba_pkg::cmd_t cmd
);
	import scba_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_LINK = 5'b00100,
		S_COMMIT = 5'b01000,
		S_OUT = 5'b10000
	} state_t;

	state_t state_q;
	logic   out_fire;

	assign out_fire  = (state_q == S_OUT) && out_ready;
	assign in_ready  = (state_q == S_IDLE) || out_fire;
	assign out_valid = (state_q == S_OUT);
	assign cmd.load   = in_valid && in_ready;
	assign cmd.read   = (state_q == S_READ);
	assign cmd.link   = (state_q == S_LINK);
	assign cmd.commit = (state_q == S_COMMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_READ;
				end
				S_READ: state_q <= S_LINK;
				S_LINK: state_q <= S_COMMIT;
				S_COMMIT: state_q <= S_OUT;
				S_OUT: begin
					if (out_ready) state_q <= in_valid ? S_READ : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/core/scba_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_dp: allocator datapath
// Page tables, class heads, link memory and the used-block counter.
// ----------------------------------------------------------------------------
module scba_dp #(
	parameter int PAGES        = 64,
	parameter int PAGE_BYTES   = 4096,
	parameter int SIZE_CLASSES = 32,
	parameter int HEADER_BYTES = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  scba_pkg::cmd_t              cmd,
	input  logic                        mode,
	input  logic [scba_pkg::SIZE_W-1:0] request_size,
	input  logic [scba_pkg::ADDR_W-1:0] release_address,
	output logic [2:0]                  status,
	output logic [scba_pkg::ADDR_W-1:0] granted_address,
	output logic [scba_pkg::USED_W-1:0] blocks_in_use
);
	import scba_pkg::*;

	localparam int PW     = $clog2(PAGES + 1);        // page+1 / unused count
	localparam int PI     = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int CI     = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
	localparam int PB_SH  = $clog2(PAGE_BYTES);
	localparam int LWORDS = 32768;
	localparam int LI     = 15;
	localparam int MAXSZ  = SIZE_CLASSES * 8;

	// blocks per fresh page for each class
	logic [COUNT_W-1:0] fresh_tab [SIZE_CLASSES];

	for (genvar g = 0; g < SIZE_CLASSES; g++) begin : g_fresh
		localparam int FRESH_N = (PAGE_BYTES - HEADER_BYTES) / ((g + 1) * 8);
		assign fresh_tab[g] = COUNT_W'(FRESH_N);
	end

	logic [PW-1:0]      head_q [SIZE_CLASSES];
	logic [PW-1:0]      unused_q;
	logic [USED_W-1:0]  used_q;
	logic [COUNT_W-1:0] cnt_mem [PAGES];
	logic [CI-1:0]      cls_mem [PAGES];
	logic [PW-1:0]      lnk_mem [PAGES];
	logic [ADDR_W-1:0]  bh_mem  [PAGES];
	logic [ADDR_W-1:0]  link_mem [LWORDS];

	// request word
	logic              mode_q;
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] raddr_q;

	// decode of the request (combinational from captured word)
	logic              bad_size, fresh, no_page, rel_zero, foreign;
	logic [CI-1:0]     a_cls;
	logic [ADDR_W-1:0] bs;
	logic [PI-1:0]     a_page, r_page, page;
	logic [ADDR_W-PB_SH-1:0] r_pfull;

	assign bad_size = (size_q == '0) || (size_q > SIZE_W'(MAXSZ));
	assign a_cls    = CI'((size_q - SIZE_W'(1)) >> 3);
	assign bs       = ADDR_W'({a_cls, 3'b000}) + ADDR_W'(8);
	assign fresh    = (head_q[a_cls] == '0);
	assign no_page  = fresh && (unused_q == '0);
	assign a_page   = fresh ? PI'(unused_q - PW'(1)) : PI'(head_q[a_cls] - PW'(1));
	assign r_pfull  = raddr_q[ADDR_W-1:PB_SH];
	assign r_page   = PI'(r_pfull);
	assign rel_zero = (raddr_q == '0);
	assign foreign  = (32'(r_pfull) >= 32'(PAGES)) || (32'(r_pfull) < 32'(unused_q));
	assign page     = mode_q ? r_page : a_page;

	// registered table reads (read stage), then link read at the block head
	logic [COUNT_W-1:0] cnt_r;
	logic [CI-1:0]      cls_r;
	logic [PW-1:0]      lnk_r;
	logic [ADDR_W-1:0]  bh_r, lk_r;
	logic [ADDR_W-1:0]  fresh_bh;

	assign fresh_bh = ADDR_W'({page, {PB_SH{1'b0}}}) + ADDR_W'(HEADER_BYTES);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			size_q  <= request_size;
			raddr_q <= release_address;
		end
		if (cmd.read) begin
			cnt_r <= cnt_mem[page];
			cls_r <= cls_mem[page];
			lnk_r <= lnk_mem[page];
			bh_r  <= bh_mem[page];
		end
		if (cmd.link) begin
			lk_r <= link_mem[bh_r[LI+2:3]];
		end
	end

	// commit-stage values
	logic [COUNT_W-1:0] cur_cnt, new_cnt;
	logic [ADDR_W-1:0]  cur_bh, cur_lk, nxt_carve;
	logic               alloc_ok, rel_ok;

	assign cur_cnt   = (mode_q == 1'b0 && fresh) ? fresh_tab[a_cls] : cnt_r;
	assign cur_bh    = (mode_q == 1'b0 && fresh) ? fresh_bh : bh_r;
	assign cur_lk    = (mode_q == 1'b0 && fresh) ? '0 : lk_r;
	assign new_cnt   = mode_q ? cur_cnt + COUNT_W'(1) : cur_cnt - COUNT_W'(1);
	assign nxt_carve = cur_bh + bs;
	assign alloc_ok  = !mode_q && !bad_size && !no_page;
	assign rel_ok    = mode_q && !rel_zero && !foreign;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (alloc_ok) begin
				cnt_mem[page] <= new_cnt;
				if (fresh) begin
					cls_mem[page] <= a_cls;
					lnk_mem[page] <= '0;
				end
				if (new_cnt != '0) begin
					if (cur_lk != '0) begin
						bh_mem[page] <= cur_lk;
					end else begin
						bh_mem[page] <= nxt_carve;
						link_mem[nxt_carve[LI+2:3]] <= '0;
					end
				end else if (fresh) begin
					bh_mem[page] <= cur_bh;
				end
			end else if (rel_ok) begin
				cnt_mem[page] <= new_cnt;
				if (cnt_r == '0) lnk_mem[page] <= head_q[cls_r];
				link_mem[raddr_q[LI+2:3]] <= bh_r;
				bh_mem[page] <= raddr_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SIZE_CLASSES; i++) head_q[i] <= '0;
			unused_q <= PW'(PAGES);
			used_q   <= '0;
			status   <= ST_OK;
			granted_address <= '0;
		end else if (cmd.commit) begin
			granted_address <= '0;
			status <= ST_OK;
			if (!mode_q) begin
				if (bad_size) begin
					status <= ST_BAD_SIZE;
				end else if (no_page) begin
					status <= ST_NO_PAGE;
				end else begin
					if (fresh) unused_q <= unused_q - PW'(1);
					if (new_cnt == '0)
						head_q[a_cls] <= fresh ? '0 : lnk_r;
					else if (fresh)
						head_q[a_cls] <= PW'(a_page) + PW'(1);
					used_q <= used_q + USED_W'(1);
					granted_address <= cur_bh;
				end
			end else if (!rel_zero) begin
				if (foreign) begin
					status <= ST_FOREIGN;
				end else begin
					if (cnt_r == '0) head_q[cls_r] <= PW'(r_page) + PW'(1);
					if (used_q != '0) used_q <= used_q - USED_W'(1);
					else status <= ST_UNDERFLOW;
				end
			end
		end
	end

	assign blocks_in_use = used_q;
endmodule

// ----- rtl/core/size_class_block_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_block_allocator_unit: segregated free-list block allocator
// Allocates and releases blocks of 32 size classes over a fixed page pool.
// ----------------------------------------------------------------------------
// Flow: each accepted word passes through the table read, link read and commit
// states before its result is valid; table and link memory reads are registered.
// A new word is taken only as the previous result leaves, not while one is in flight.
// Reset: arst_n clears class heads and used count, sets the unused page count
// to PAGES; page tables and link memory are not cleared, need no clearing pass.
module size_class_block_allocator_unit #(
	parameter int PAGES        = 64,
	parameter int PAGE_BYTES   = 4096,
	parameter int SIZE_CLASSES = 32,
	parameter int HEADER_BYTES = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        mode,
	input  logic [scba_pkg::SIZE_W-1:0] request_size,
	input  logic [scba_pkg::ADDR_W-1:0] release_address,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  status,
	output logic [scba_pkg::ADDR_W-1:0] granted_address,
	output logic [scba_pkg::USED_W-1:0] blocks_in_use
);
	import scba_pkg::*;

	cmd_t cmd;

	// sequencer: one word in flight, result held until taken
	scba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd)
	);

	// tables, link memory and counters
	scba_dp #(
		.PAGES(PAGES), .PAGE_BYTES(PAGE_BYTES),
		.SIZE_CLASSES(SIZE_CLASSES), .HEADER_BYTES(HEADER_BYTES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.mode(mode), .request_size(request_size),
		.release_address(release_address),
		.status(status), .granted_address(granted_address),
		.blocks_in_use(blocks_in_use)
	);

	// a failed item leaves no granted address
	a_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> granted_address == '0)
		else $error("grant on failure");

	// a word is never taken while the previous one is mid-flight
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read |-> !in_ready)
		else $error("overlap");

	// count changes only on a commit
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cmd.commit) |-> $stable(blocks_in_use))
		else $error("count changed without commit");
endmodule
